FILE: hdl/prcc_pkg.sv
`timescale 1ns / 1ps
package prcc_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF   = 32;

   // request modes
   localparam logic [1:0] MODE_CLEAR    = 2'd0;
   localparam logic [1:0] MODE_APPEND   = 2'd1;
   localparam logic [1:0] MODE_COUNT    = 2'd2;
   localparam logic [1:0] MODE_CONTAINS = 2'd3;

   localparam logic [1:0] MUL_AY_BX = 2'd0;
   localparam logic [1:0] MUL_AX_BY = 2'd1;
   localparam logic [1:0] MUL_DY_RL = 2'd2;

   // reach of the contains ray is 2^34 LSB
   localparam int REACH_BITS     = 36;
   localparam int CONTAINS_SHIFT = 34;

   localparam int LEN_BITS = 31;

   localparam logic CSR_IDX_CLOSED = 1'b0;

   typedef struct packed {
      logic       ld_query;
      logic       wr_vertex;
      logic       rd;
      logic       ld_first;
      logic       ld_next;
      logic       ld_close;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       acc_ld;
      logic       acc_sub;
      logic       decide;
   } prcc_cmd_type;

endpackage

FILE: hdl/polygon_ray_crossing_counter.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports
// req       in         req_valid/req_ready, mode, x_coord, y_coord, along_y, ray_length
// rsp       out        rsp_valid/rsp_ready, crossing_count, inside_res, status
// csr       in         csr_psel/penable/pwrite/paddr/pwdata, prdata, pready
//
// Clear and append go straight to the finish state. A query over n stored
// vertices reads each vertex once; each edge, the closing one too, takes three
// passes through the single shared multiplier and a decision step; n = 0 skips both.
// Reset is synchronous: vertex count 0, polygon_closed 1, no word pending.
// A result word waits in the output register; a new word is taken meanwhile,
// and its result holds until the pending word leaves.
module polygon_ray_crossing_counter
   import prcc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [31:0]         req_x_coord,
   input  logic [31:0]         req_y_coord,
   input  logic                req_along_y,
   input  logic [LEN_BITS-1:0] req_ray_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [6:0]          rsp_crossing_count,
   output logic                rsp_inside_res,
   output logic                rsp_status,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   prcc_cmd_type  cmd;
   logic [AW-1:0] mem_addr;
   logic [CW-1:0] hits;
   logic          closed_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == CSR_IDX_CLOSED)) begin
         closed_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CLOSED) ? {31'd0, closed_ff} : 32'd0;

   prcc_ctrl #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_crossing_count(rsp_crossing_count),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_status        (rsp_status),
      .closed            (closed_ff),
      .hits              (hits),
      .cmd               (cmd),
      .mem_addr          (mem_addr)
   );

   prcc_dpath #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS  (COORD_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .mem_addr      (mem_addr),
      .req_mode      (req_mode),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .req_along_y   (req_along_y),
      .req_ray_length(req_ray_length),
      .hits          (hits)
   );

endmodule

FILE: hdl/prcc_dpath.sv
`timescale 1ns / 1ps
module prcc_dpath
   import prcc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF,
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  prcc_cmd_type        cmd,
   input  logic [AW-1:0]       mem_addr,
   input  logic [1:0]          req_mode,
   input  logic [31:0]         req_x_coord,
   input  logic [31:0]         req_y_coord,
   input  logic                req_along_y,
   input  logic [LEN_BITS-1:0] req_ray_length,
   output logic [CW-1:0]       hits
);

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int MW = (DW + 1 > REACH_BITS) ? DW + 1 : REACH_BITS;
   localparam int PW = 2 * MW;
   localparam int SW = PW + 2;

   logic [CB-1:0] mem_x [MAX_VERTICES];
   logic [CB-1:0] mem_y [MAX_VERTICES];
   logic [CB-1:0] qx_x_ff, qx_y_ff;
   logic [CB-1:0] qx_ff, qy_ff;
   logic          swap_ff;
   logic [REACH_BITS-1:0] reach_ff;

   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff, fx_ff, fy_ff;
   logic signed [DW-1:0] dx, dy_n, dy_raw;
   logic signed [MW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [SW-1:0] acc_ff, s1, s2;
   logic signed [DW:0]   ey;
   logic [CW-1:0]        hits_ff, hits_in;
   logic                 hit;

   always_ff @(posedge clock) begin
      if (cmd.wr_vertex) begin
         mem_x[mem_addr] <= req_x_coord[CB-1:0];
         mem_y[mem_addr] <= req_y_coord[CB-1:0];
      end
      if (cmd.rd) begin
         qx_x_ff <= mem_x[mem_addr];
         qx_y_ff <= mem_y[mem_addr];
      end
   end

   // swap axes for a count ray along +y
   always_ff @(posedge clock) begin
      if (cmd.ld_query) begin
         swap_ff <= (req_mode == MODE_COUNT) && req_along_y;
         if ((req_mode == MODE_COUNT) && req_along_y) begin
            qx_ff <= req_y_coord[CB-1:0];
            qy_ff <= req_x_coord[CB-1:0];
         end else begin
            qx_ff <= req_x_coord[CB-1:0];
            qy_ff <= req_y_coord[CB-1:0];
         end
         if (req_mode == MODE_CONTAINS) begin
            reach_ff <= REACH_BITS'(1) << CONTAINS_SHIFT;
         end else begin
            reach_ff <= REACH_BITS'(req_ray_length);
         end
      end
   end

   always_comb begin
      logic [CB-1:0] vx, vy;
      vx = swap_ff ? qx_y_ff : qx_x_ff;
      vy = swap_ff ? qx_x_ff : qx_y_ff;
      dx = $signed({vx[CB-1], vx}) - $signed({qx_ff[CB-1], qx_ff});
      dy_raw = $signed({vy[CB-1], vy}) - $signed({qy_ff[CB-1], qy_ff});
      // nudge a vertex on the ray line just below it
      dy_n = (dy_raw == '0) ? '1 : dy_raw;
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_first) begin
         ax_ff <= dx; ay_ff <= dy_n;
         fx_ff <= dx; fy_ff <= dy_n;
         bx_ff <= dx; by_ff <= dy_n;
      end
      if (cmd.ld_next) begin
         bx_ff <= dx; by_ff <= dy_n;
      end
      if (cmd.decide) begin
         ax_ff <= bx_ff; ay_ff <= by_ff;
      end
      if (cmd.ld_close) begin
         bx_ff <= fx_ff; by_ff <= fy_ff;
      end
   end

   assign ey = $signed({by_ff[DW-1], by_ff}) - $signed({ay_ff[DW-1], ay_ff});

   always_comb begin
      case (cmd.mul_sel)
         MUL_AY_BX: begin
            op_a = MW'(ay_ff);
            op_b = MW'(bx_ff);
         end
         MUL_AX_BY: begin
            op_a = MW'(ax_ff);
            op_b = MW'(by_ff);
         end
         default: begin
            op_a = MW'(ey);
            op_b = $signed(MW'(reach_ff));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (cmd.acc_ld) begin
         acc_ff <= SW'(prod_ff);
      end else if (cmd.acc_sub) begin
         acc_ff <= acc_ff - SW'(prod_ff);
      end
   end

   // s1: orientation at one LSB, s2: at the far end of the ray
   assign s1 = acc_ff + SW'(ey);
   assign s2 = acc_ff + SW'(prod_ff);
   assign hit = (ay_ff[DW-1] != by_ff[DW-1]) &&
                ((s1 == '0) || (s2 == '0) || (s1[SW-1] != s2[SW-1]));

   always_comb begin
      hits_in = hits_ff;
      if (cmd.ld_query) begin
         hits_in = '0;
      end else if (cmd.decide && hit) begin
         hits_in = hits_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff <= '0;
      end else begin
         hits_ff <= hits_in;
      end
   end

   assign hits = hits_ff;

endmodule

FILE: hdl/prcc_ctrl.sv
`timescale 1ns / 1ps
module prcc_ctrl
   import prcc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_mode,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [6:0]    rsp_crossing_count,
   output logic          rsp_inside_res,
   output logic          rsp_status,
   input  logic          closed,
   input  logic [CW-1:0] hits,
   output prcc_cmd_type  cmd,
   output logic [AW-1:0] mem_addr
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_LD   = 3'd2;
   localparam logic [2:0] S_M0   = 3'd3;
   localparam logic [2:0] S_M1   = 3'd4;
   localparam logic [2:0] S_M2   = 3'd5;
   localparam logic [2:0] S_DEC  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in;
   logic          first_ff, first_in, close_ff, close_in;
   logic          stat_ff, stat_in;
   logic [1:0]    mode_ff, mode_in;
   logic          rv_ff, rv_in;
   logic [6:0]    rc_ff, rc_in;
   logic          ri_ff, ri_in, rs_ff, rs_in;
   logic          accept;
   logic [CW-1:0] idx_nx;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign idx_nx    = idx_ff + CW'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      first_in = first_ff;
      close_in = close_ff;
      stat_in  = stat_ff;
      mode_in  = mode_ff;
      rv_in    = rv_ff && !rsp_ready;
      rc_in    = rc_ff;
      ri_in    = ri_ff;
      rs_in    = rs_ff;
      cmd      = '0;
      mem_addr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.ld_query = 1'b1;
               mode_in  = req_mode;
               stat_in  = 1'b0;
               idx_in   = '0;
               first_in = 1'b1;
               close_in = 1'b0;
               state_in = S_FIN;
               case (req_mode)
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  MODE_APPEND: begin
                     mem_addr = count_ff[AW-1:0];
                     if (count_ff >= CW'(MAX_VERTICES)) begin
                        stat_in = 1'b1;
                     end else begin
                        cmd.wr_vertex = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  default: begin
                     if (count_ff != '0) begin
                        state_in = S_RD;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_LD;
         end
         S_LD: begin
            state_in = S_M0;
            if (first_ff) begin
               cmd.ld_first = 1'b1;
               first_in = 1'b0;
               idx_in   = idx_nx;
               if (idx_nx < count_ff) begin
                  state_in = S_RD;
               end else begin
                  close_in = 1'b1;
               end
            end else begin
               cmd.ld_next = 1'b1;
            end
         end
         S_M0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AY_BX;
            state_in    = S_M1;
         end
         S_M1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AX_BY;
            cmd.acc_ld  = 1'b1;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DY_RL;
            cmd.acc_sub = 1'b1;
            state_in    = S_DEC;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            if (close_ff) begin
               state_in = S_FIN;
            end else begin
               idx_in = idx_nx;
               if (idx_nx < count_ff) begin
                  state_in = S_RD;
               end else begin
                  // wrap back to the first vertex
                  cmd.ld_close = 1'b1;
                  close_in = 1'b1;
                  state_in = S_M0;
               end
            end
         end
         S_FIN: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rc_in    = 7'(hits);
               ri_in    = (mode_ff == MODE_CONTAINS) && closed && hits[0];
               rs_in    = stat_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      first_ff <= first_in;
      close_ff <= close_in;
      stat_ff  <= stat_in;
      mode_ff  <= mode_in;
      rc_ff    <= rc_in;
      ri_ff    <= ri_in;
      rs_ff    <= rs_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_crossing_count = rc_ff;
   assign rsp_inside_res     = ri_ff;
   assign rsp_status         = rs_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count above capacity");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the store");

   a_read_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> idx_ff < count_ff)
      else $error("read past the stored vertices");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_APPEND) && (count_ff == CW'(MAX_VERTICES))
      |=> stat_ff && (count_ff == CW'(MAX_VERTICES)))
      else $error("append to a full store not dropped");

endmodule
